// ----- src/twd_pkg.sv -----
// ----------------------------------------------------------------------------
// twd_pkg: shared types and constants
// Widths, register indexes, reference kinds and helpers of the timed window
// displacement unit.
// ----------------------------------------------------------------------------
package twd_pkg;

   localparam int HISTORY_DEPTH = 32;
   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   localparam int STAMP_W    = 48;
   localparam int POS_W      = 32;
   localparam int LOOKBACK_W = 24;
   localparam int KEEP_W     = 24;
   localparam int GAP_W      = 16;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int KIND_W     = 2;

   localparam int FRAC_W  = 16;
   localparam int RATIO_W = FRAC_W + 1;
   localparam int DIFF_W  = POS_W + 1;
   localparam int PROD_W  = DIFF_W + RATIO_W + 1;
   localparam int DCNT_W  = $clog2(RATIO_W);

   localparam logic [CSR_IDX_W-1:0] CSR_LOOKBACK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP  = 2'd2;

   localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET = 24'd1000000;
   localparam logic [KEEP_W-1:0]     KEEP_RESET     = 24'd1500000;
   localparam logic [GAP_W-1:0]      MIN_GAP_RESET  = 16'd1;

   localparam logic [KIND_W-1:0] KIND_OLDEST   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TINY_GAP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INTERP   = 2'd2;

   // signed stamp, one bit wider than a raw stamp
   typedef logic signed [STAMP_W:0] tstamp_type;
   typedef logic signed [POS_W-1:0] pos_type;

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [DIFF_W-1:0] d);
      logic [POS_W-1:0] r;
      if (d[DIFF_W-1] != d[POS_W-1]) begin
         r = d[DIFF_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         r = d[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- src/timed_window_displacement_unit.sv -----
// ----------------------------------------------------------------------------
// timed_window_displacement_unit
// Keeps a ring history of stamped positions, finds the lookback reference
// (taken or interpolated) and returns the saturated displacement.
// ----------------------------------------------------------------------------
// Steps: a write, then an age check (read, compare) of each dropped entry and
//   of the first kept one, then a read and compare of each scanned entry; an
//   interpolation adds a restoring divide and the multiply and sum steps for x
//   and y, before the output step. One item at a time: a new request is taken
//   only after the result register is loaded, which may wait on rsp_ready.
// Reset: history empties, CSR registers return to their defaults; stored entries
//   keep old contents and are never read before written.
// ----------------------------------------------------------------------------
module timed_window_displacement_unit import twd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [STAMP_W-1:0]    req_stamp_us,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [POS_W-1:0] rsp_delta_x,
   output logic signed [POS_W-1:0] rsp_delta_y,
   output logic [KIND_W-1:0]     rsp_reference_kind,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_WRITE    = 4'd1;
   localparam logic [3:0] S_DROP_RD  = 4'd2;
   localparam logic [3:0] S_DROP_CHK = 4'd3;
   localparam logic [3:0] S_SCAN_RD  = 4'd4;
   localparam logic [3:0] S_SCAN_CHK = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_MUL_X    = 4'd7;
   localparam logic [3:0] S_MUL_Y    = 4'd8;
   localparam logic [3:0] S_INT_Y    = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(RATIO_W - 1);
   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

   logic [3:0]            state_ff, state_in;
   logic [LOOKBACK_W-1:0] lookback_ff;
   logic [KEEP_W-1:0]     keep_ff;
   logic [GAP_W-1:0]      min_gap_ff;

   logic [STAMP_W-1:0]    now_ff, now_in;
   pos_type               cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   tstamp_type            target_ff, target_in;
   logic [IDX_W-1:0]      oldest_ff, oldest_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;

   logic [STAMP_W-1:0]    stamp_mem [HISTORY_DEPTH];
   logic [POS_W-1:0]      x_mem [HISTORY_DEPTH];
   logic [POS_W-1:0]      y_mem [HISTORY_DEPTH];
   logic                  mem_we;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic [STAMP_W-1:0]    rd_stamp_ff;
   pos_type               rd_x_ff, rd_y_ff;

   logic [STAMP_W-1:0]    prev_stamp_ff, prev_stamp_in;
   pos_type               prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [STAMP_W-1:0]    dt_ff, dt_in;
   logic [STAMP_W:0]      rem_ff, rem_in;
   logic [RATIO_W-1:0]    quot_ff, quot_in;
   logic [DCNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   pos_type               ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_dx_ff, rsp_dx_in, rsp_dy_ff, rsp_dy_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;

   logic                  too_old, qualifies, tiny_gap, div_ge, out_free;
   tstamp_type            dt_full;
   logic signed [STAMP_W+1:0] num_full;
   logic [STAMP_W-1:0]    num_clamp;
   logic [STAMP_W:0]      rem_sub;
   logic signed [DIFF_W-1:0] mul_a;
   logic signed [PROD_W-1:0] mul_res, interp_sum, prev_sel;

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_delta_x        = rsp_dx_ff;
   assign rsp_delta_y        = rsp_dy_ff;
   assign rsp_reference_kind = rsp_kind_ff;

   assign wr_addr = oldest_ff + count_ff[IDX_W-1:0];
   assign rd_addr = oldest_ff + scan_ff[IDX_W-1:0];

   assign too_old   = (now_ff > rd_stamp_ff) &&
                      ((now_ff - rd_stamp_ff) > {{(STAMP_W-KEEP_W){1'b0}}, keep_ff});
   assign qualifies = ($signed({1'b0, rd_stamp_ff}) >= target_ff);
   assign dt_full   = $signed({1'b0, rd_stamp_ff}) - $signed({1'b0, prev_stamp_ff});
   assign tiny_gap  = (dt_full <= 0) ||
                      (dt_full < $signed({{(STAMP_W+1-GAP_W){1'b0}}, min_gap_ff}));
   assign num_full  = $signed({target_ff[STAMP_W], target_ff}) -
                      $signed({2'b00, prev_stamp_ff});

   always_comb begin
      if (num_full < 0) begin
         num_clamp = '0;
      end else if (num_full > $signed({dt_full[STAMP_W], dt_full})) begin
         num_clamp = dt_full[STAMP_W-1:0];
      end else begin
         num_clamp = num_full[STAMP_W-1:0];
      end
   end

   assign div_ge  = (rem_ff >= {1'b0, dt_ff});
   assign rem_sub = div_ge ? (rem_ff - {1'b0, dt_ff}) : rem_ff;

   assign mul_a      = (state_ff == S_MUL_X) ? dx_ff : dy_ff;
   assign mul_res    = mul_a * $signed({1'b0, quot_ff});
   assign prev_sel   = (state_ff == S_MUL_Y) ? PROD_W'(prev_x_ff) : PROD_W'(prev_y_ff);
   assign interp_sum = prev_sel + ((prod_ff + ROUND_HALF) >>> FRAC_W);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      target_in     = target_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      mem_we        = 1'b0;
      prev_stamp_in = prev_stamp_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      dt_in         = dt_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      div_cnt_in    = div_cnt_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      prod_in       = prod_ff;
      ref_x_in      = ref_x_ff;
      ref_y_in      = ref_y_ff;
      kind_in       = kind_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_dx_in     = rsp_dx_ff;
      rsp_dy_in     = rsp_dy_ff;
      rsp_kind_in   = rsp_kind_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in    = req_stamp_us;
               cur_x_in  = req_pos_x;
               cur_y_in  = req_pos_y;
               target_in = $signed({1'b0, req_stamp_us}) -
                           $signed({{(STAMP_W+1-LOOKBACK_W){1'b0}}, lookback_ff});
               state_in  = S_WRITE;
            end
         end
         S_WRITE: begin
            // a full ring overwrites its oldest slot
            mem_we  = 1'b1;
            scan_in = '0;
            if (count_ff == DEPTH_CNT) begin
               oldest_in = oldest_ff + 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_DROP_RD;
         end
         S_DROP_RD: begin
            state_in = S_DROP_CHK;
         end
         S_DROP_CHK: begin
            if (too_old) begin
               oldest_in = oldest_ff + 1'b1;
               count_in  = count_ff - 1'b1;
               state_in  = S_DROP_RD;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (qualifies) begin
               ref_x_in = rd_x_ff;
               ref_y_in = rd_y_ff;
               if (scan_ff == '0) begin
                  kind_in  = KIND_OLDEST;
                  state_in = S_DONE;
               end else if (tiny_gap) begin
                  kind_in  = KIND_TINY_GAP;
                  state_in = S_DONE;
               end else begin
                  kind_in    = KIND_INTERP;
                  dt_in      = dt_full[STAMP_W-1:0];
                  rem_in     = {1'b0, num_clamp};
                  quot_in    = '0;
                  div_cnt_in = '0;
                  dx_in      = {rd_x_ff[POS_W-1], rd_x_ff} - {prev_x_ff[POS_W-1], prev_x_ff};
                  dy_in      = {rd_y_ff[POS_W-1], rd_y_ff} - {prev_y_ff[POS_W-1], prev_y_ff};
                  state_in   = S_DIV;
               end
            end else begin
               prev_stamp_in = rd_stamp_ff;
               prev_x_in     = rd_x_ff;
               prev_y_in     = rd_y_ff;
               scan_in       = scan_ff + 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle, MSB first
            quot_in    = {quot_ff[RATIO_W-2:0], div_ge};
            rem_in     = {rem_sub[STAMP_W-1:0], 1'b0};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            prod_in  = mul_res;
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            ref_x_in = interp_sum[POS_W-1:0];
            prod_in  = mul_res;
            state_in = S_INT_Y;
         end
         S_INT_Y: begin
            ref_y_in = interp_sum[POS_W-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dx_in    = sat_pos({cur_x_ff[POS_W-1], cur_x_ff} -
                                      {ref_x_ff[POS_W-1], ref_x_ff});
               rsp_dy_in    = sat_pos({cur_y_ff[POS_W-1], cur_y_ff} -
                                      {ref_y_ff[POS_W-1], ref_y_ff});
               rsp_kind_in  = kind_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lookback_ff  <= LOOKBACK_RESET;
         keep_ff      <= KEEP_RESET;
         min_gap_ff   <= MIN_GAP_RESET;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOOKBACK: lookback_ff <= csr_wdata[LOOKBACK_W-1:0];
               CSR_KEEP:     keep_ff     <= csr_wdata[KEEP_W-1:0];
               CSR_MIN_GAP:  min_gap_ff  <= csr_wdata[GAP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      target_ff     <= target_in;
      scan_ff       <= scan_in;
      prev_stamp_ff <= prev_stamp_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      dt_ff         <= dt_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      div_cnt_ff    <= div_cnt_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      prod_ff       <= prod_in;
      ref_x_ff      <= ref_x_in;
      ref_y_ff      <= ref_y_in;
      kind_ff       <= kind_in;
      rsp_dx_ff     <= rsp_dx_in;
      rsp_dy_ff     <= rsp_dy_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   // history memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[wr_addr] <= now_ff;
         x_mem[wr_addr]     <= cur_x_ff;
         y_mem[wr_addr]     <= cur_y_ff;
      end
      rd_stamp_ff <= stamp_mem[rd_addr];
      rd_x_ff     <= x_mem[rd_addr];
      rd_y_ff     <= y_mem[rd_addr];
   end

   a_accept_to_write: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_WRITE))
      else $error("accepted item did not enter the write step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= DEPTH_CNT))
      else $error("history count above depth");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CHK) |-> (count_ff != '0) && (scan_ff < count_ff))
      else $error("scan outside valid history");

   a_ratio_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_cnt_ff == DIV_LAST) |=> (quot_ff <= RATIO_ONE))
      else $error("interpolation ratio above one");

endmodule
